FILE: hw/rtl/median_filter_2d_assert.svh
// ----------------------------------------------------------------------------
// median_filter_2d_assert.svh
// assertion macros shared by the median filter rtl, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_2D_ASSERT_SVH
`define MEDIAN_FILTER_2D_ASSERT_SVH

// same-cycle implication
`define MF2D_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MF2D_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mf2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_pkg
// shared types and constants of the 2d median filter
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int unsigned WIN_DIM_DEF   = 3;
    localparam int unsigned MAX_WIDTH_DEF = 1024;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned HEIGHT_W   = 16;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd8;
    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd8;

    typedef logic [PIX_W-1:0] pix_t;

    // configuration register index
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    // item control travelling with a window into / out of the sorter
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

endpackage

FILE: hw/rtl/mf2d_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_sort
// pipelined odd-even transposition sorter with median pick and output register
// ----------------------------------------------------------------------------
`include "median_filter_2d_assert.svh"

module mf2d_sort #(
    parameter int unsigned WIN_DIM = mf2d_pkg::WIN_DIM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mf2d_pkg::ctl_t  in_ctl,
    output logic            in_ready,
    input  mf2d_pkg::pix_t  in_data [WIN_DIM*WIN_DIM],
    output mf2d_pkg::ctl_t  out_ctl,
    input  logic            out_ready,
    output mf2d_pkg::pix_t  out_data
);
    import mf2d_pkg::*;

    localparam int unsigned N  = WIN_DIM * WIN_DIM;
    localparam int unsigned NS = N + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] last_reg;
    pix_t          d_reg [NS][N];
    pix_t          cx    [N][N];
    logic [NS:0]   en;
    logic          out_valid_reg;
    logic          out_last_reg;
    pix_t          out_data_reg;
    pix_t          mid;

    // one compare-exchange layer per stage, even layers on even pairs
    always_comb
    begin
        for (int s = 0; s < N; s++)
        begin
            for (int i = 0; i < N; i++)
            begin
                cx[s][i] = d_reg[s][i];
            end
            for (int i = 0; i + 1 < N; i++)
            begin
                if ((i % 2) == (s % 2) && d_reg[s][i] > d_reg[s][i+1])
                begin
                    cx[s][i]   = d_reg[s][i+1];
                    cx[s][i+1] = d_reg[s][i];
                end
            end
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NS] = !out_valid_reg || out_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_ctl.valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
            if (en[NS])
            begin
                out_valid_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg[0]    <= in_data;
            last_reg[0] <= in_ctl.last;
        end
        for (int s = 1; s < NS; s++)
        begin
            if (en[s])
            begin
                d_reg[s]    <= cx[s-1];
                last_reg[s] <= last_reg[s-1];
            end
        end
        if (en[NS])
        begin
            out_data_reg <= mid;
            out_last_reg <= last_reg[NS-1];
        end
    end

    // middle of the sorted window, mean of the two middles for even counts
    if ((N % 2) == 0)
    begin : g_even
        assign mid = PIX_W'(({1'b0, d_reg[N][N/2-1]} + {1'b0, d_reg[N][N/2]}) >> 1);
    end
    else
    begin : g_odd
        assign mid = d_reg[N][N/2];
    end

    assign out_ctl.valid = out_valid_reg;
    assign out_ctl.last  = out_last_reg;
    assign out_data      = out_data_reg;

    for (genvar gi = 0; gi + 1 < N; gi++)
    begin : g_chk
        `MF2D_ASSERT_IMP(a_sorted, v_reg[N], d_reg[N][gi] <= d_reg[N][gi+1], "sort out of order")
    end
    `MF2D_ASSERT_IMP(a_ready_when_empty, !out_valid_reg, in_ready, "sorter stalls while empty")
    `MF2D_ASSERT_NXT(a_out_load, v_reg[N] && en[NS], out_valid_reg, "sorted window lost")

endmodule

FILE: hw/rtl/median_filter_2d.sv
`timescale 1ns / 1ps
// path: a taken pixel passes the line memory read, one sort layer per stage and the output
//   register before its result appears
// throughput: one pixel per cycle while m_tready holds; the line memory has one read and one
//   write port and takes one read and one write per pixel, a same-column hazard is forwarded
// reset: counters, valid bits and window clear at once, registers return to 8 x 8;
//   the line memory is not cleared and the block takes pixels right after reset
// ----------------------------------------------------------------------------
// median_filter_2d
// streaming window x window median filter over 8-bit pixels, valid-mode output
// ----------------------------------------------------------------------------
`include "median_filter_2d_assert.svh"

module median_filter_2d #(
    parameter int unsigned WIN_DIM   = mf2d_pkg::WIN_DIM_DEF,
    parameter int unsigned MAX_WIDTH = mf2d_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  mf2d_pkg::cfg_idx_t                  cfg_addr,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // pixel input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] median_value
    output logic                                m_tlast    // frame_last
);
    import mf2d_pkg::*;

    localparam int unsigned N       = WIN_DIM * WIN_DIM;
    localparam int unsigned LS_ROWS = (WIN_DIM > 1) ? WIN_DIM - 1 : 1;
    localparam int unsigned LS_W    = LS_ROWS * PIX_W;
    localparam int unsigned AW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMPW    = (WW > WIDTH_W) ? WW : WIDTH_W;

    // configuration and frame position
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [AW-1:0]       col_reg;
    logic [AW-1:0]       col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;

    logic [CMPW-1:0]     width_ext;
    logic [WW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [WW-1:0]       col_ext;
    logic [WW-1:0]       col_plus1;
    logic [HEIGHT_W:0]   row_plus1;
    logic                end_col;
    logic                end_row;
    logic                in_last;
    logic                in_pass;
    logic                in_res;
    logic                accept;

    // stage 1: item waiting on its line memory read
    logic                v1_reg;
    logic [AW-1:0]       s1_addr_reg;
    pix_t                s1_px_reg;
    logic                s1_res_reg;
    logic                s1_pass_reg;
    logic                s1_last_reg;
    logic                fire1;

    // line memory: one word holds the column of all stored rows
    logic [LS_W-1:0]     ls_mem [MAX_WIDTH];
    logic [LS_W-1:0]     ls_rd_reg;
    logic [LS_W-1:0]     ls_rd;
    logic [LS_W-1:0]     ls_wdata;
    logic                fwd_reg;
    logic [LS_W-1:0]     fwd_data_reg;

    pix_t                col_pix [WIN_DIM];
    pix_t                win_reg  [WIN_DIM][WIN_DIM];
    pix_t                win_next [WIN_DIM][WIN_DIM];
    pix_t                sort_in  [N];
    ctl_t                sort_in_ctl;
    logic                sort_ready;
    ctl_t                sort_out_ctl;
    pix_t                sort_out_data;

    // ------------------------------------------------------------------
    // effective frame size: zero acts as one, width saturates
    // ------------------------------------------------------------------
    always_comb
    begin
        width_ext = CMPW'(width_reg);
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (width_ext > CMPW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_ext[WW-1:0];
        end
        eff_h = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    assign col_ext   = WW'(col_reg);
    assign col_plus1 = col_ext + WW'(1);
    assign row_plus1 = {1'b0, row_reg} + (HEIGHT_W + 1)'(1);
    assign end_col   = col_plus1 >= eff_w;
    assign end_row   = row_plus1 >= {1'b0, eff_h};
    assign in_last   = end_col && end_row;

    // small frames pass through; otherwise only full windows give a result
    assign in_pass = (WW'(WIN_DIM) >= eff_w) || (HEIGHT_W'(WIN_DIM) >= eff_h);
    assign in_res  = in_pass ||
                     ((col_ext >= WW'(WIN_DIM - 1)) &&
                      (row_reg >= HEIGHT_W'(WIN_DIM - 1)));

    assign fire1    = v1_reg && sort_ready;
    assign s_tready = !v1_reg || sort_ready;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // frame position counters, a register write starts a new frame
    // ------------------------------------------------------------------
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (end_col)
            begin
                col_next = '0;
                row_next = row_plus1[HEIGHT_W-1:0];
            end
            else
            begin
                col_next = col_plus1[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1 control and same-column forwarding
    // a read issued in the cycle that writes the same column sees old data,
    // so the written word is kept and replaces the read result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg  <= 1'b1;
                fwd_reg <= fire1 && (s1_addr_reg == col_reg);
            end
            else if (fire1)
            begin
                v1_reg  <= 1'b0;
                fwd_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= col_reg;
            s1_px_reg    <= s_tdata;
            s1_res_reg   <= in_res;
            s1_pass_reg  <= in_pass;
            s1_last_reg  <= in_last;
            fwd_data_reg <= ls_wdata;
        end
    end

    // line memory: read on accept, write back when the item leaves stage 1
    always_ff @(posedge clk)
    begin
        if (fire1)
        begin
            ls_mem[s1_addr_reg] <= ls_wdata;
        end
        if (accept)
        begin
            ls_rd_reg <= ls_mem[col_reg];
        end
    end

    assign ls_rd = fwd_reg ? fwd_data_reg : ls_rd_reg;

    // new window column: stored rows oldest first, then the incoming pixel;
    // each stored row moves up by one
    always_comb
    begin
        ls_wdata = '0;
        for (int k = 0; k + 1 < WIN_DIM; k++)
        begin
            col_pix[k] = ls_rd[k*PIX_W +: PIX_W];
        end
        col_pix[WIN_DIM-1] = s1_px_reg;
        for (int k = 0; k + 1 < WIN_DIM; k++)
        begin
            ls_wdata[k*PIX_W +: PIX_W] = col_pix[k+1];
        end
    end

    // window shifts left one column per item
    always_comb
    begin
        for (int k = 0; k < WIN_DIM; k++)
        begin
            for (int j = 0; j + 1 < WIN_DIM; j++)
            begin
                win_next[k][j] = win_reg[k][j+1];
            end
            win_next[k][WIN_DIM-1] = col_pix[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DIM; k++)
            begin
                for (int j = 0; j < WIN_DIM; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (fire1)
        begin
            win_reg <= win_next;
        end
    end

    // pass-through fills the whole sorter with the pixel, its median is the pixel
    always_comb
    begin
        for (int k = 0; k < WIN_DIM; k++)
        begin
            for (int j = 0; j < WIN_DIM; j++)
            begin
                sort_in[k*WIN_DIM + j] = s1_pass_reg ? s1_px_reg : win_next[k][j];
            end
        end
    end

    assign sort_in_ctl.valid = v1_reg && s1_res_reg;
    assign sort_in_ctl.last  = s1_last_reg;

    mf2d_sort #(
        .WIN_DIM (WIN_DIM)
    ) u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (sort_in_ctl),
        .in_ready  (sort_ready),
        .in_data   (sort_in),
        .out_ctl   (sort_out_ctl),
        .out_ready (m_tready),
        .out_data  (sort_out_data)
    );

    assign m_tvalid = sort_out_ctl.valid;
    assign m_tlast  = sort_out_ctl.last;
    assign m_tdata  = sort_out_data;

    `MF2D_ASSERT_IMP(a_fwd_needs_item, fwd_reg, v1_reg, "forwarded line data without an item")
    `MF2D_ASSERT_IMP(a_col_in_frame, 1'b1, col_ext < eff_w, "column counter beyond frame width")
    `MF2D_ASSERT_IMP(a_row_in_frame, 1'b1, row_reg < eff_h, "row counter beyond frame height")

endmodule
